>>> src/isaac_keystream_window_assert.svh
// Assertion macros shared by the keystream window design.
`ifndef ISAAC_KEYSTREAM_WINDOW_ASSERT_SVH
`define ISAAC_KEYSTREAM_WINDOW_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define IKW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must hold in the cycle after the trigger.
`define IKW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);
`else
`define IKW_ASSERT(lbl, prop, msg)
`define IKW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> src/ikw_pkg.sv
// Types and constants of the keystream window block.
package ikw_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned WINDOW_LIMIT = 100;
  localparam int unsigned WIN_DEPTH    = 128;
  localparam int unsigned WIN_AW       = $clog2(WIN_DEPTH);
  localparam int unsigned CNT_W        = $clog2(WINDOW_LIMIT + 1);
  localparam int unsigned TBL_DEPTH    = 256;
  localparam int unsigned TBL_AW       = $clog2(TBL_DEPTH);

  localparam logic [WORD_W-1:0] GOLDEN       = 32'h9E37_79B9;
  localparam logic [WORD_W-1:0] RESEED_START = 32'd2;

  // Opcodes on the input channel.
  typedef enum logic [1:0] {
    OP_RESEED = 2'd0,
    OP_GET    = 2'd1,
    OP_PURGE  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Command kinds handed from the front end to the back end.
  typedef enum logic [1:0] {
    K_NOP    = 2'd0,
    K_RESEED = 2'd1,
    K_GET    = 2'd2,
    K_PURGE  = 2'd3
  } cmd_kind_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOT_INIT = 3'd1,
    ST_PURGED   = 3'd2,
    ST_AHEAD    = 3'd3,
    ST_IGNORED  = 3'd4
  } status_e;

  typedef struct packed {
    logic              valid;
    cmd_kind_e         kind;
    logic [WORD_W-1:0] seq;
  } ikw_cmd_t;

  typedef struct packed {
    logic reseed;
    logic next;
  } ikw_core_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              word_valid;
    logic [WORD_W-1:0] word;
  } ikw_core_rsp_t;

endpackage

>>> src/ikw_if.sv
// Handshake interfaces for the request and result channels.
interface ikw_in_if import ikw_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [WORD_W-1:0] sequence_req;

  modport source (output valid, opcode, sequence_req, input ready);
  modport sink (input valid, opcode, sequence_req, output ready);
endinterface

interface ikw_out_if import ikw_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  logic [2:0]        status;

  modport source (output valid, word, status, input ready);
  modport sink (input valid, word, status, output ready);
endinterface

>>> src/ikw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ikw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ikw_front.sv
// Front end: accepts requests, classifies the opcode and queues commands.
module ikw_front import ikw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  ikw_in_if.sink   in_ch,
  output ikw_cmd_t cmd_o,
  input  logic     cmd_pop_i
);

  localparam int unsigned QD  = 2;
  localparam int unsigned QAW = $clog2(QD);

  cmd_kind_e         kind_q [QD];
  logic [WORD_W-1:0] seq_q [QD];
  logic [QAW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QAW:0]      cnt_q, cnt_d;
  cmd_kind_e         kind;
  logic              push, pop;

  // Opcode classification.
  always_comb begin
    unique case (op_e'(in_ch.opcode))
      OP_RESEED: kind = K_RESEED;
      OP_GET:    kind = K_GET;
      OP_PURGE:  kind = K_PURGE;
      default:   kind = K_NOP;
    endcase
  end

  assign in_ch.ready = (cnt_q != (QAW+1)'(QD));
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = cmd_pop_i && (cnt_q != '0);

  // Queue pointers and fill level.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == QAW'(QD - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == QAW'(QD - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      kind_q[wptr_q] <= kind;
      seq_q[wptr_q]  <= in_ch.sequence_req;
    end
  end

  assign cmd_o.valid = (cnt_q != '0);
  assign cmd_o.kind  = kind_q[rptr_q];
  assign cmd_o.seq   = seq_q[rptr_q];

endmodule

>>> src/ikw_core.sv
// ISAAC engine: seed register, table set-up, generation passes and word reads.
module ikw_core import ikw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WORD_W-1:0] cfg_wdata_i,
  input  ikw_core_req_t     req_i,
  output ikw_core_rsp_t     rsp_o
);

  typedef enum logic [14:0] {
    C_IDLE   = 15'b000000000000001,
    C_WRET   = 15'b000000000000010,
    C_PREMIX = 15'b000000000000100,
    C_BMIX   = 15'b000000000001000,
    C_BWR    = 15'b000000000010000,
    C_BRD    = 15'b000000000100000,
    C_BADD   = 15'b000000001000000,
    C_GEN0   = 15'b000000010000000,
    C_GEN1   = 15'b000000100000000,
    C_GRX    = 15'b000001000000000,
    C_GRH    = 15'b000010000000000,
    C_GA     = 15'b000100000000000,
    C_GY     = 15'b001000000000000,
    C_GRY    = 15'b010000000000000,
    C_GB     = 15'b100000000000000
  } core_state_e;

  core_state_e state_q, state_d;

  logic [WORD_W-1:0] seed_q;
  logic [WORD_W-1:0] a_q, a_d, b_q, b_d, c_q, c_d;
  logic [TBL_AW-1:0] rc_q, rc_d, gi_q, gi_d;
  logic [WORD_W-1:0] v_q [8];
  logic [WORD_W-1:0] v_d [8];
  logic [WORD_W-1:0] v_mix [8];
  logic [2:0]        k_q, k_d, j_q, j_d;
  logic [1:0]        rnd_q, rnd_d;
  logic [4:0]        blk_q, blk_d;
  logic              pass_q, pass_d, rs_q, rs_d;
  logic [WORD_W-1:0] x_q, x_d, y_q, y_d;
  logic [WORD_W-1:0] mix_sh, mix_nk, gen_sh, y_new, b_new;

  logic              mm_we, mm_re, rt_we, rt_re;
  logic [TBL_AW-1:0] mm_waddr, mm_raddr, rt_waddr;
  logic [WORD_W-1:0] mm_wdata, mm_rdata, rt_wdata, rt_rdata;

  ikw_ram #(.WIDTH(WORD_W), .DEPTH(TBL_DEPTH)) u_mix_mem (
    .clk_i   (clk_i),
    .we_i    (mm_we),
    .waddr_i (mm_waddr),
    .wdata_i (mm_wdata),
    .re_i    (mm_re),
    .raddr_i (mm_raddr),
    .rdata_o (mm_rdata)
  );

  ikw_ram #(.WIDTH(WORD_W), .DEPTH(TBL_DEPTH)) u_result_mem (
    .clk_i   (clk_i),
    .we_i    (rt_we),
    .waddr_i (rt_waddr),
    .wdata_i (rt_wdata),
    .re_i    (rt_re),
    .raddr_i (rc_q),
    .rdata_o (rt_rdata)
  );

  // One step of the eight-word mixing function, selected by k_q.
  always_comb begin
    case (k_q)
      3'd0:    mix_sh = v_q[1] << 11;
      3'd1:    mix_sh = v_q[2] >> 2;
      3'd2:    mix_sh = v_q[3] << 8;
      3'd3:    mix_sh = v_q[4] >> 16;
      3'd4:    mix_sh = v_q[5] << 10;
      3'd5:    mix_sh = v_q[6] >> 4;
      3'd6:    mix_sh = v_q[7] << 8;
      default: mix_sh = v_q[0] >> 9;
    endcase
    mix_nk = v_q[k_q] ^ mix_sh;
    for (int i = 0; i < 8; i++) begin
      v_mix[i] = v_q[i];
    end
    v_mix[k_q]        = mix_nk;
    v_mix[k_q + 3'd3] = v_q[k_q + 3'd3] + mix_nk;
    v_mix[k_q + 3'd1] = v_q[k_q + 3'd1] + v_q[k_q + 3'd2];
  end

  // Accumulator shift of a generation step, chosen by the low index bits.
  always_comb begin
    case (gi_q[1:0])
      2'd0:    gen_sh = a_q << 13;
      2'd1:    gen_sh = a_q >> 6;
      2'd2:    gen_sh = a_q << 2;
      default: gen_sh = a_q >> 16;
    endcase
  end

  assign y_new = mm_rdata + a_q + b_q;
  assign b_new = mm_rdata + x_q;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    rc_d    = rc_q;
    gi_d    = gi_q;
    k_d     = k_q;
    j_d     = j_q;
    rnd_d   = rnd_q;
    blk_d   = blk_q;
    pass_d  = pass_q;
    rs_d    = rs_q;
    x_d     = x_q;
    y_d     = y_q;
    for (int i = 0; i < 8; i++) begin
      v_d[i] = v_q[i];
    end
    mm_we    = 1'b0;
    mm_waddr = gi_q;
    mm_wdata = y_new;
    mm_re    = 1'b0;
    mm_raddr = gi_q;
    rt_we    = 1'b0;
    rt_waddr = gi_q;
    rt_wdata = b_new;
    rt_re    = 1'b0;
    rsp_o.busy       = (state_q != C_IDLE);
    rsp_o.done       = 1'b0;
    rsp_o.word_valid = 1'b0;
    rsp_o.word       = rt_rdata;

    unique case (state_q)
      C_IDLE: begin
        if (req_i.reseed) begin
          a_d   = seed_q;
          b_d   = seed_q;
          c_d   = seed_q;
          k_d   = '0;
          rnd_d = '0;
          rs_d  = 1'b1;
          for (int i = 0; i < 8; i++) begin
            v_d[i] = GOLDEN;
          end
          state_d = C_PREMIX;
        end else if (req_i.next) begin
          rt_re   = 1'b1;
          state_d = C_WRET;
        end
      end
      C_WRET: begin
        rsp_o.word_valid = 1'b1;
        if (rc_q != '0) begin
          rc_d    = rc_q - 1'b1;
          state_d = C_IDLE;
        end else begin
          rc_d    = '1;
          rs_d    = 1'b0;
          state_d = C_GEN0;
        end
      end
      C_PREMIX: begin
        for (int i = 0; i < 8; i++) begin
          v_d[i] = v_mix[i];
        end
        k_d = k_q + 1'b1;
        if (k_q == 3'd7) begin
          rnd_d = rnd_q + 1'b1;
          if (rnd_q == 2'd3) begin
            blk_d   = '0;
            pass_d  = 1'b0;
            state_d = C_BMIX;
          end
        end
      end
      C_BMIX: begin
        for (int i = 0; i < 8; i++) begin
          v_d[i] = v_mix[i];
        end
        k_d = k_q + 1'b1;
        if (k_q == 3'd7) begin
          j_d     = '0;
          state_d = C_BWR;
        end
      end
      C_BWR: begin
        mm_we    = 1'b1;
        mm_waddr = {blk_q, j_q};
        mm_wdata = v_q[j_q];
        j_d      = j_q + 1'b1;
        if (j_q == 3'd7) begin
          if (blk_q == 5'd31) begin
            blk_d = '0;
            if (!pass_q) begin
              pass_d  = 1'b1;
              state_d = C_BRD;
            end else begin
              state_d = C_GEN0;
            end
          end else begin
            blk_d   = blk_q + 1'b1;
            state_d = pass_q ? C_BRD : C_BMIX;
          end
        end
      end
      C_BRD: begin
        mm_re    = 1'b1;
        mm_raddr = {blk_q, j_q};
        state_d  = C_BADD;
      end
      C_BADD: begin
        v_d[j_q] = v_q[j_q] + mm_rdata;
        j_d      = j_q + 1'b1;
        state_d  = (j_q == 3'd7) ? C_BMIX : C_BRD;
      end
      C_GEN0: begin
        c_d     = c_q + 1'b1;
        state_d = C_GEN1;
      end
      C_GEN1: begin
        b_d     = b_q + c_q;
        gi_d    = '0;
        state_d = C_GRX;
      end
      C_GRX: begin
        mm_re   = 1'b1;
        state_d = C_GRH;
      end
      C_GRH: begin
        x_d      = mm_rdata;
        mm_re    = 1'b1;
        mm_raddr = gi_q + TBL_AW'(TBL_DEPTH / 2);
        state_d  = C_GA;
      end
      C_GA: begin
        a_d      = (a_q ^ gen_sh) + mm_rdata;
        mm_re    = 1'b1;
        mm_raddr = x_q[TBL_AW+1:2];
        state_d  = C_GY;
      end
      C_GY: begin
        mm_we   = 1'b1;
        y_d     = y_new;
        state_d = C_GRY;
      end
      C_GRY: begin
        mm_re    = 1'b1;
        mm_raddr = y_q[TBL_AW+9:10];
        state_d  = C_GB;
      end
      C_GB: begin
        rt_we = 1'b1;
        b_d   = b_new;
        gi_d  = gi_q + 1'b1;
        if (gi_q == '1) begin
          rc_d       = '1;
          rsp_o.done = rs_q;
          state_d    = C_IDLE;
        end else begin
          state_d = C_GRX;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  // Control state and accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      seed_q  <= '0;
      a_q     <= '0;
      b_q     <= '0;
      c_q     <= '0;
      rc_q    <= '1;
      gi_q    <= '0;
      k_q     <= '0;
      j_q     <= '0;
      rnd_q   <= '0;
      blk_q   <= '0;
      pass_q  <= 1'b0;
      rs_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      a_q    <= a_d;
      b_q    <= b_d;
      c_q    <= c_d;
      rc_q   <= rc_d;
      gi_q   <= gi_d;
      k_q    <= k_d;
      j_q    <= j_d;
      rnd_q  <= rnd_d;
      blk_q  <= blk_d;
      pass_q <= pass_d;
      rs_q   <= rs_d;
    end
  end

  // Working registers of the mixer and the generation step.
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    for (int i = 0; i < 8; i++) begin
      v_q[i] <= v_d[i];
    end
  end

endmodule

>>> src/ikw_back.sv
// Back end: sequence window, window buffer, command execution and result register.
module ikw_back import ikw_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ikw_cmd_t      cmd_i,
  output logic          cmd_pop_o,
  output ikw_core_req_t core_req_o,
  input  ikw_core_rsp_t core_rsp_i,
  ikw_out_if.source     out_ch
);

  typedef enum logic [4:0] {
    B_IDLE   = 5'b00001,
    B_RSWAIT = 5'b00010,
    B_GCHK   = 5'b00100,
    B_GWAIT  = 5'b01000,
    B_RDWAIT = 5'b10000
  } back_state_e;

  back_state_e state_q, state_d;

  logic [WORD_W-1:0] start_q, start_d, seq_q, seq_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_word_q, out_word_d;
  status_e           out_status_q, out_status_d;

  logic              out_free;
  logic [WORD_W:0]   start_x, fill_end, lim_end, cseq_x, seq_x;
  logic [WORD_W-1:0] diff;
  logic              win_we, win_re;
  logic [WIN_AW-1:0] win_waddr;
  logic [WORD_W-1:0] win_rdata;

  ikw_ram #(.WIDTH(WORD_W), .DEPTH(WIN_DEPTH)) u_window_mem (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (win_waddr),
    .wdata_i (core_rsp_i.word),
    .re_i    (win_re),
    .raddr_i (seq_q[WIN_AW-1:0]),
    .rdata_o (win_rdata)
  );

  // Comparisons are made one bit wider so that the window never wraps.
  assign start_x   = {1'b0, start_q};
  assign fill_end  = start_x + (WORD_W+1)'(count_q);
  assign lim_end   = start_x + (WORD_W+1)'(WINDOW_LIMIT);
  assign cseq_x    = {1'b0, cmd_i.seq};
  assign seq_x     = {1'b0, seq_q};
  assign diff      = cmd_i.seq - start_q;
  assign win_waddr = WIN_AW'(start_q + WORD_W'(count_q));
  assign out_free  = !out_valid_q || out_ch.ready;

  always_comb begin
    state_d      = state_q;
    start_d      = start_q;
    count_d      = count_q;
    seq_d        = seq_q;
    out_valid_d  = out_valid_q && !out_ch.ready;
    out_word_d   = out_word_q;
    out_status_d = out_status_q;
    cmd_pop_o    = 1'b0;
    core_req_o   = '0;
    win_we       = 1'b0;
    win_re       = 1'b0;

    unique case (state_q)
      B_IDLE: begin
        if (cmd_i.valid && out_free && !core_rsp_i.busy) begin
          cmd_pop_o    = 1'b1;
          out_word_d   = '0;
          out_status_d = ST_OK;
          unique case (cmd_i.kind)
            K_RESEED: begin
              core_req_o.reseed = 1'b1;
              state_d           = B_RSWAIT;
            end
            K_GET: begin
              if (start_q == '0) begin
                out_valid_d  = 1'b1;
                out_status_d = ST_NOT_INIT;
              end else if (cseq_x < start_x) begin
                out_valid_d  = 1'b1;
                out_status_d = ST_PURGED;
              end else if (cseq_x >= lim_end) begin
                out_valid_d  = 1'b1;
                out_status_d = ST_AHEAD;
              end else begin
                seq_d   = cmd_i.seq;
                state_d = B_GCHK;
              end
            end
            K_PURGE: begin
              out_valid_d = 1'b1;
              if (start_q == '0) begin
                out_status_d = ST_NOT_INIT;
              end else if (cseq_x >= fill_end) begin
                out_status_d = ST_IGNORED;
              end else if (cseq_x >= start_x) begin
                // Purging through the last sequence number closes the window.
                if (cmd_i.seq == '1) begin
                  start_d = '0;
                  count_d = '0;
                end else begin
                  start_d = cmd_i.seq + 1'b1;
                  count_d = count_q - CNT_W'(diff) - 1'b1;
                end
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      B_RSWAIT: begin
        if (core_rsp_i.done) begin
          start_d      = RESEED_START;
          count_d      = '0;
          out_valid_d  = 1'b1;
          out_word_d   = '0;
          out_status_d = ST_OK;
          state_d      = B_IDLE;
        end
      end
      B_GCHK: begin
        if (seq_x >= fill_end) begin
          if (!core_rsp_i.busy) begin
            core_req_o.next = 1'b1;
            state_d         = B_GWAIT;
          end
        end else begin
          win_re  = 1'b1;
          state_d = B_RDWAIT;
        end
      end
      B_GWAIT: begin
        if (core_rsp_i.word_valid) begin
          win_we  = 1'b1;
          count_d = count_q + 1'b1;
          state_d = B_GCHK;
        end
      end
      B_RDWAIT: begin
        out_valid_d  = 1'b1;
        out_word_d   = win_rdata;
        out_status_d = ST_OK;
        state_d      = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      start_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload and the sequence being served.
  always_ff @(posedge clk_i) begin
    seq_q        <= seq_d;
    out_word_q   <= out_word_d;
    out_status_q <= out_status_d;
  end

  assign out_ch.valid  = out_valid_q;
  assign out_ch.word   = out_word_q;
  assign out_ch.status = out_status_q;

endmodule

>>> src/isaac_keystream_window.sv
// Top level of the ISAAC keystream window block.
//
//  Channel   Direction  Handshake     Payload
//  in_ch     in         valid/ready   opcode, sequence_req
//  out_ch    out        valid/ready   word, status
//  cfg       in         cfg_we_i      cfg_wdata_i (seed)
//
// A get of an already generated word reads it from the window buffer; each
// new word is fetched from the engine by the registered read of its result
// table. Every 256th word starts a generation pass (four mix memory reads
// and one write per step on a single read port).
// Reset clears all control state; tables are written before they are read.
// A two-entry command queue accepts up to two transfers while results stall.
`include "isaac_keystream_window_assert.svh"

module isaac_keystream_window import ikw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WORD_W-1:0] cfg_wdata_i,
  ikw_in_if.sink            in_ch,
  ikw_out_if.source         out_ch
);

  ikw_cmd_t      cmd;
  logic          cmd_pop;
  ikw_core_req_t core_req;
  ikw_core_rsp_t core_rsp;

  ikw_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .cmd_o     (cmd),
    .cmd_pop_i (cmd_pop)
  );

  ikw_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (core_req),
    .rsp_o       (core_rsp)
  );

  ikw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .core_req_o (core_req),
    .core_rsp_i (core_rsp),
    .out_ch     (out_ch)
  );

  // The engine is only ever asked for one thing, and only when it is free.
  `IKW_ASSERT(a_req_single, !(core_req.reseed && core_req.next), "two core requests at once")
  `IKW_ASSERT(a_req_idle, (core_req.reseed || core_req.next) |-> !core_rsp.busy, "busy core")
  // A queued command stays until the back end takes it.
  `IKW_ASSERT_NEXT(a_cmd_hold, cmd.valid && !cmd_pop, cmd.valid, "queued command lost")

endmodule

>>> dv/ikw_checker.sv
// Checker for the keystream window: predicts every result and compares it.
`timescale 1ns / 1ps

module ikw_checker import ikw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WORD_W-1:0] cfg_wdata_i,
  ikw_in_if                 in_ch,
  ikw_out_if                out_ch,
  output int                fail_count_o,
  output int                outstanding_o
);

  // Shadow copy of the generator and window state.
  logic [31:0] seed_reg;
  logic [31:0] mix_mem [256];
  logic [31:0] rsl_tbl [256];
  logic [31:0] win_buf [128];
  logic [31:0] acc_a, acc_b, acc_c;
  logic [31:0] mixv [8];
  int unsigned rd_idx;
  logic [31:0] win_start;
  int unsigned win_cnt;

  // Expected results, oldest first.
  logic [31:0] exp_word_q [$];
  status_e     exp_status_q [$];

  task automatic mix_one(int k, logic [31:0] sh);
    mixv[k] = mixv[k] ^ sh;
    mixv[(k + 3) & 7] = mixv[(k + 3) & 7] + mixv[k];
    mixv[(k + 1) & 7] = mixv[(k + 1) & 7] + mixv[(k + 2) & 7];
  endtask

  task automatic mix_all();
    mix_one(0, mixv[1] << 11);
    mix_one(1, mixv[2] >> 2);
    mix_one(2, mixv[3] << 8);
    mix_one(3, mixv[4] >> 16);
    mix_one(4, mixv[5] << 10);
    mix_one(5, mixv[6] >> 4);
    mix_one(6, mixv[7] << 8);
    mix_one(7, mixv[0] >> 9);
  endtask

  // One full pass over the mix memory, refilling the result table.
  function automatic void regenerate();
    logic [31:0] x, y, sh;
    acc_c = acc_c + 1;
    acc_b = acc_b + acc_c;
    for (int i = 0; i < 256; i++) begin
      x = mix_mem[i];
      case (i & 3)
        0: sh = acc_a << 13;
        1: sh = acc_a >> 6;
        2: sh = acc_a << 2;
        default: sh = acc_a >> 16;
      endcase
      acc_a = (acc_a ^ sh) + mix_mem[(i + 128) & 255];
      y = mix_mem[(x >> 2) & 255] + acc_a + acc_b;
      mix_mem[i] = y;
      acc_b = mix_mem[(y >> 10) & 255] + x;
      rsl_tbl[i] = acc_b;
    end
  endfunction

  // Reseed: clear the results, load the seed, run the table set-up, regenerate.
  task automatic reseed();
    for (int i = 0; i < 256; i++) rsl_tbl[i] = '0;
    acc_a = seed_reg;
    acc_b = seed_reg;
    acc_c = seed_reg;
    for (int j = 0; j < 8; j++) mixv[j] = GOLDEN;
    for (int i = 0; i < 4; i++) mix_all();
    for (int p = 0; p < 2; p++) begin
      for (int i = 0; i < 256; i += 8) begin
        for (int j = 0; j < 8; j++)
          mixv[j] = mixv[j] + ((p == 0) ? rsl_tbl[i + j] : mix_mem[i + j]);
        mix_all();
        for (int j = 0; j < 8; j++) mix_mem[i + j] = mixv[j];
      end
    end
    regenerate();
    rd_idx = 255;
    win_cnt = 0;
    win_start = RESEED_START;
  endtask

  function automatic logic [31:0] draw_word();
    logic [31:0] w;
    w = rsl_tbl[rd_idx];
    if (rd_idx > 0) begin
      rd_idx--;
    end else begin
      regenerate();
      rd_idx = 255;
    end
    return w;
  endfunction

  // Works out the result of one accepted request and queues it.
  task automatic predict(op_e op, logic [31:0] seq_req);
    longint unsigned seq, start, s;
    logic [31:0] word;
    status_e st;
    seq = longint'(seq_req);
    start = longint'(win_start);
    word = '0;
    st = ST_OK;
    case (op)
      OP_RESEED: reseed();
      OP_GET: begin
        if (win_start == 0) begin
          st = ST_NOT_INIT;
        end else if (seq < start) begin
          st = ST_PURGED;
        end else if (seq >= start + WINDOW_LIMIT) begin
          st = ST_AHEAD;
        end else begin
          while (seq >= start + win_cnt) begin
            s = start + win_cnt;
            win_buf[s & 127] = draw_word();
            win_cnt++;
          end
          word = win_buf[seq & 127];
        end
      end
      OP_PURGE: begin
        if (win_start == 0) begin
          st = ST_NOT_INIT;
        end else if (seq >= start + win_cnt) begin
          st = ST_IGNORED;
        end else if (seq >= start) begin
          win_cnt = win_cnt - int'(seq - start + 1);
          win_start = seq_req + 1;
          if (win_start == 0) win_cnt = 0;
        end
      end
      default: ;
    endcase
    exp_word_q.insert(exp_word_q.size(), word);
    exp_status_q.insert(exp_status_q.size(), st);
  endtask

  // Watch all three ports at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_reg = '0;
      acc_a = '0;
      acc_b = '0;
      acc_c = '0;
      rd_idx = 255;
      win_start = '0;
      win_cnt = 0;
      fail_count_o = 0;
      exp_word_q.delete();
      exp_status_q.delete();
      outstanding_o = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (exp_word_q.size() == 0) begin
          $error("result transfer with nothing expected: word %h status %0d",
                 out_ch.word, out_ch.status);
          fail_count_o++;
        end else begin
          if (out_ch.word !== exp_word_q[0]) begin
            $error("word: expected %h, actual %h", exp_word_q[0], out_ch.word);
            fail_count_o++;
          end
          if (out_ch.status !== exp_status_q[0]) begin
            $error("status: expected %0d, actual %0d", exp_status_q[0], out_ch.status);
            fail_count_o++;
          end
          exp_word_q.delete(0);
          exp_status_q.delete(0);
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict(op_e'(in_ch.opcode), in_ch.sequence_req);
      if (cfg_we_i) seed_reg = cfg_wdata_i;
      outstanding_o = exp_word_q.size();
    end
  end

endmodule

>>> dv/tb_top.sv
// Testbench top: clock, reset, stimulus and verdict for the keystream window.
`timescale 1ns / 1ps

module tb_top;
  import ikw_pkg::*;

  localparam int CYCLE_LIMIT = 5_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int          fail_count;
  int          outstanding;
  int          cycles;
  bit          idle_en;
  bit          hold_req;
  int          n_get, n_purge, n_reseed;
  logic [31:0] base, hi;

  ikw_in_if  in_ch ();
  ikw_out_if out_ch ();

  isaac_keystream_window uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  ikw_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && hold_left == 0) hold_left = 400;
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) hold_req = 1'b0;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idle_en && $urandom_range(99) < 15);
      end
    end
  end

  // Offers one request and waits for its transfer.
  task automatic send(op_e op, logic [31:0] seq);
    @(negedge clk_i);
    if (idle_en && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.sequence_req <= seq;
    case (op)
      OP_GET: n_get++;
      OP_PURGE: n_purge++;
      OP_RESEED: n_reseed++;
      default: ;
    endcase
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Drains every outstanding result, then idles before returning.
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_seed(logic [31:0] value);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Random requests that mostly walk the window forward.
  task automatic random_items(int count);
    int r;
    logic [31:0] s;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 4) begin
        send(OP_RESEED, $urandom);
        base = 2;
        hi = 1;
      end else if (r < 6) begin
        send(OP_NONE, $urandom);
      end else if (r < 11) begin
        send(($urandom_range(1) != 0) ? OP_GET : OP_PURGE, $urandom);
      end else if (r < 70) begin
        s = base + $urandom_range(0, 104);
        if (s < base + WINDOW_LIMIT && s > hi) hi = s;
        send(OP_GET, s);
      end else if (r < 76) begin
        send(OP_GET, base - $urandom_range(1, 3));
      end else if (hi >= base) begin
        s = base + $urandom_range(0, hi - base);
        send(OP_PURGE, s);
        base = s + 1;
      end else begin
        send(OP_PURGE, base + $urandom_range(0, 8));
      end
    end
  endtask

  initial begin
    logic [31:0] seeds [7];
    idle_en = 1'b1;
    hold_req = 1'b0;
    n_get = 0;
    n_purge = 0;
    n_reseed = 0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_NONE;
    in_ch.sequence_req = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: before initialisation, edges of the window, purges.
    write_seed(32'h0);
    send(OP_GET, 32'd5);
    send(OP_PURGE, 32'd5);
    send(OP_NONE, 32'hFFFF_FFFF);
    send(OP_RESEED, 32'd0);
    send(OP_GET, 32'd2);
    send(OP_GET, 32'd0);
    send(OP_GET, 32'd101);
    send(OP_GET, 32'd102);
    send(OP_GET, 32'hFFFF_FFFF);
    send(OP_GET, 32'd50);
    send(OP_PURGE, 32'd200);
    send(OP_PURGE, 32'd0);
    send(OP_PURGE, 32'd40);
    send(OP_GET, 32'd40);
    send(OP_GET, 32'd140);
    send(OP_PURGE, 32'd140);
    send(OP_NONE, 32'h0);
    drain();

    // Random phases, each with its own seed; the sender drains in between.
    seeds[0] = 32'hFFFF_FFFF;
    for (int i = 1; i < 7; i++) seeds[i] = $urandom;
    for (int ph = 0; ph < 7; ph++) begin
      write_seed(seeds[ph]);
      idle_en = (ph != 3);
      if (ph == 1) hold_req = 1'b1;
      send(OP_RESEED, 32'h0);
      base = 2;
      hi = 1;
      random_items(105);
      drain();
    end

    $display("Covered %0d gets, %0d purges and %0d reseeds over 8 seed settings,",
             n_get, n_purge, n_reseed);
    $display("with random idling, one long result hold-off and drains between phases.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
